### design/ac3c_pkg.sv
package ac3c_pkg;

   localparam int CompW   = 16;              // Q8.8 component
   localparam int RegW    = 3 * CompW;       // packed xyz register
   localparam int CrossW  = 2 * CompW + 1;   // cofactor entry
   localparam int OffW    = CompW + 1;       // point minus origin
   localparam int ProdW   = OffW + CrossW;   // offset times cofactor
   localparam int DetW    = 52;              // determinant, Q24.24 with headroom
   localparam int MagW    = DetW - 1;        // determinant magnitude
   localparam int FracW   = 16;              // fraction bits of the result
   localparam int QuotW   = 33;              // quotient bits before clamping
   localparam int LoW     = QuotW - FracW;   // dividend bits fed during the steps
   localparam int CoordW  = 32;
   localparam int IdxW    = 3;

   localparam logic [IdxW-1:0] RegOrigin = 3'd0;
   localparam logic [IdxW-1:0] RegAxisX  = 3'd1;
   localparam logic [IdxW-1:0] RegAxisY  = 3'd2;
   localparam logic [IdxW-1:0] RegAxisZ  = 3'd3;

   localparam logic [RegW-1:0] OriginRst = 48'd0;
   localparam logic [RegW-1:0] AxisXRst  = 48'd256;
   localparam logic [RegW-1:0] AxisYRst  = 48'd16777216;
   localparam logic [RegW-1:0] AxisZRst  = 48'd1099511627776;

   localparam logic [QuotW-1:0] PosLimit = 33'h0_7FFF_FFFF;
   localparam logic [QuotW-1:0] NegLimit = 33'h0_8000_0000;

   typedef logic signed [CompW-1:0]  comp_type;
   typedef logic signed [CrossW-1:0] cross_type;
   typedef logic signed [DetW-1:0]   det_type;
   typedef logic [MagW-1:0]          mag_type;

   typedef struct packed {
      cross_type x;
      cross_type y;
      cross_type z;
   } vec_type;

   // config-derived values; the user keeps them stable while beats are in flight, the block does not enforce it
   typedef struct packed {
      comp_type ox;
      comp_type oy;
      comp_type oz;
      vec_type  cof_x;   // ay cross az
      vec_type  cof_y;   // az cross ax
      vec_type  cof_z;   // ax cross ay
      mag_type  dmag;
      logic     dneg;
      logic     dzero;
   } basis_type;

   typedef struct packed {
      det_type nx;
      det_type ny;
      det_type nz;
   } numer_type;

endpackage

### design/ac3c_basis.sv
module ac3c_basis (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ac3c_pkg::IdxW-1:0]       csr_index,
   input  logic [ac3c_pkg::RegW-1:0]       csr_wdata,
   output ac3c_pkg::basis_type             basis
);
   import ac3c_pkg::*;

   localparam int Nxt [3] = '{1, 2, 0};
   localparam int Prv [3] = '{2, 0, 1};

   logic [RegW-1:0] origin_ff, axis_x_ff, axis_y_ff, axis_z_ff;

   comp_type                 ax [3];
   comp_type                 ay [3];
   comp_type                 az [3];
   comp_type                 a  [3][3];
   logic signed [2*CompW-1:0] pp_ff [3][3][2];
   cross_type                cr_ff [3][3];
   logic signed [CompW+CrossW-1:0] dp_ff [3];
   det_type                  dsum_ff;
   det_type                  dneg_w;
   mag_type                  dmag_ff;
   logic                     dneg_ff, dzero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= OriginRst;
         axis_x_ff <= AxisXRst;
         axis_y_ff <= AxisYRst;
         axis_z_ff <= AxisZRst;
      end else if (csr_we) begin
         case (csr_index)
            RegOrigin: origin_ff <= csr_wdata;
            RegAxisX:  axis_x_ff <= csr_wdata;
            RegAxisY:  axis_y_ff <= csr_wdata;
            RegAxisZ:  axis_z_ff <= csr_wdata;
            default:   ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ax[i] = axis_x_ff[CompW*i +: CompW];
         ay[i] = axis_y_ff[CompW*i +: CompW];
         az[i] = axis_z_ff[CompW*i +: CompW];
         a[0][i] = ax[i];
         a[1][i] = ay[i];
         a[2][i] = az[i];
      end
   end

   // cofactor j = a[j+1] cross a[j+2]; products, then differences
   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            pp_ff[j][i][0] <= a[Nxt[j]][Nxt[i]] * a[Prv[j]][Prv[i]];
            pp_ff[j][i][1] <= a[Nxt[j]][Prv[i]] * a[Prv[j]][Nxt[i]];
            cr_ff[j][i]    <= CrossW'(pp_ff[j][i][0]) - CrossW'(pp_ff[j][i][1]);
         end
      end
   end

   // det = ax dot (ay cross az)
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++)
         dp_ff[i] <= ax[i] * cr_ff[0][i];
      dsum_ff  <= det_type'(dp_ff[0]) + det_type'(dp_ff[1]) + det_type'(dp_ff[2]);
      dmag_ff  <= dneg_w[MagW-1:0];
      dneg_ff  <= dsum_ff[DetW-1];
      dzero_ff <= (dsum_ff == '0);
   end

   assign dneg_w = dsum_ff[DetW-1] ? -dsum_ff : dsum_ff;

   assign basis.ox    = origin_ff[0       +: CompW];
   assign basis.oy    = origin_ff[CompW   +: CompW];
   assign basis.oz    = origin_ff[2*CompW +: CompW];
   assign basis.cof_x = '{x: cr_ff[0][0], y: cr_ff[0][1], z: cr_ff[0][2]};
   assign basis.cof_y = '{x: cr_ff[1][0], y: cr_ff[1][1], z: cr_ff[1][2]};
   assign basis.cof_z = '{x: cr_ff[2][0], y: cr_ff[2][1], z: cr_ff[2][2]};
   assign basis.dmag  = dmag_ff;
   assign basis.dneg  = dneg_ff;
   assign basis.dzero = dzero_ff;

endmodule

### design/ac3c_numer.sv
module ac3c_numer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ac3c_pkg::comp_type    in_x,
   input  ac3c_pkg::comp_type    in_y,
   input  ac3c_pkg::comp_type    in_z,
   input  ac3c_pkg::basis_type   basis,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ac3c_pkg::numer_type   out_numer
);
   import ac3c_pkg::*;

   localparam int NS = 4;

   logic [NS-1:0]           vld_ff;
   logic [NS:0]             rdy;
   comp_type                pt_ff  [3];
   logic signed [OffW-1:0]  off_ff [3];
   logic signed [ProdW-1:0] prod_ff [3][3];
   det_type                 num_ff [3];
   comp_type                org    [3];
   cross_type               cof    [3][3];

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--)
         rdy[k] = !vld_ff[k] || rdy[k+1];
   end

   always_comb begin
      org[0] = basis.ox;
      org[1] = basis.oy;
      org[2] = basis.oz;
      cof[0] = '{basis.cof_x.x, basis.cof_x.y, basis.cof_x.z};
      cof[1] = '{basis.cof_y.x, basis.cof_y.y, basis.cof_y.z};
      cof[2] = '{basis.cof_z.x, basis.cof_z.y, basis.cof_z.z};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++)
            if (rdy[k]) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         pt_ff[0] <= in_x;
         pt_ff[1] <= in_y;
         pt_ff[2] <= in_z;
      end
      if (rdy[1])
         for (int i = 0; i < 3; i++)
            off_ff[i] <= OffW'(pt_ff[i]) - OffW'(org[i]);
      if (rdy[2])
         for (int j = 0; j < 3; j++)
            for (int i = 0; i < 3; i++)
               prod_ff[j][i] <= off_ff[i] * cof[j][i];
      if (rdy[3])
         for (int j = 0; j < 3; j++)
            num_ff[j] <= det_type'(prod_ff[j][0]) + det_type'(prod_ff[j][1])
                       + det_type'(prod_ff[j][2]);
   end

   assign in_ready     = rdy[0];
   assign out_valid    = vld_ff[NS-1];
   assign out_numer.nx = num_ff[0];
   assign out_numer.ny = num_ff[1];
   assign out_numer.nz = num_ff[2];

endmodule

### design/ac3c_div.sv
module ac3c_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  ac3c_pkg::numer_type              in_numer,
   input  ac3c_pkg::basis_type              basis,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic signed [ac3c_pkg::CoordW-1:0] out_coord [3],
   output logic                             out_singular
);
   import ac3c_pkg::*;

   // stage 0: magnitude/sign, stages 1..QuotW+1: remainder chain, last: clamp
   localparam int NR = QuotW + 1;
   localparam int NS = NR + 2;

   logic [NS-1:0]       vld_ff;
   logic [NS:0]         rdy;
   det_type             num_w  [3];
   det_type             abs_w  [3];
   mag_type             amag_ff [3];
   logic                aneg_ff [3];
   mag_type             rem_ff [NR][3];
   logic [QuotW-1:0]    q_ff   [NR][3];
   logic [LoW-1:0]      lo_ff  [NR][3];
   logic                neg_ff [NR][3];
   logic                sat_ff [NR][3];
   logic signed [CoordW-1:0] coord_ff [3];
   logic                sing_ff;

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--)
         rdy[k] = !vld_ff[k] || rdy[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++)
            if (rdy[k]) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_comb begin
      num_w[0] = in_numer.nx;
      num_w[1] = in_numer.ny;
      num_w[2] = in_numer.nz;
      for (int l = 0; l < 3; l++)
         abs_w[l] = num_w[l][DetW-1] ? -num_w[l] : num_w[l];
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      // magnitude and numerator sign
      always_ff @(posedge clock) begin
         if (rdy[0]) begin
            amag_ff[l] <= abs_w[l][MagW-1:0];
            aneg_ff[l] <= num_w[l][DetW-1];
         end
      end

      // upper dividend bits seed the remainder; seed >= divisor means overflow
      // determinant sign joins here, after it has settled from a csr write
      always_ff @(posedge clock) begin
         if (rdy[1]) begin
            rem_ff[0][l] <= amag_ff[l] >> LoW;
            sat_ff[0][l] <= (amag_ff[l] >> LoW) >= basis.dmag;
            lo_ff[0][l]  <= amag_ff[l][LoW-1:0];
            neg_ff[0][l] <= aneg_ff[l] ^ basis.dneg;
            q_ff[0][l]   <= '0;
         end
      end

      for (genvar k = 0; k < QuotW; k++) begin : g_step
         localparam int Bit = QuotW - 1 - k;
         logic [MagW:0] trial;
         logic          din;
         logic          take;
         if (Bit >= FracW) begin : g_hi
            assign din = lo_ff[k][l][Bit-FracW];
         end else begin : g_lo
            assign din = 1'b0;
         end
         always_comb begin
            trial = {rem_ff[k][l], din};
            take  = trial >= {1'b0, basis.dmag};
         end
         always_ff @(posedge clock) begin
            if (rdy[k+2]) begin
               rem_ff[k+1][l] <= take ? MagW'(trial - {1'b0, basis.dmag})
                                      : trial[MagW-1:0];
               q_ff[k+1][l]   <= q_ff[k][l] | (QuotW'(take) << Bit);
               lo_ff[k+1][l]  <= lo_ff[k][l];
               neg_ff[k+1][l] <= neg_ff[k][l];
               sat_ff[k+1][l] <= sat_ff[k][l];
            end
         end
      end

      // clamp and apply sign
      logic [QuotW-1:0] mag;
      logic [QuotW-1:0] negv;
      always_comb begin
         mag = sat_ff[NR-1][l] ? NegLimit : q_ff[NR-1][l];
         if (mag > NegLimit) mag = NegLimit;
         negv = QuotW'(0) - mag;
      end
      always_ff @(posedge clock) begin
         if (rdy[NS-1]) begin
            if (basis.dzero)
               coord_ff[l] <= '0;
            else if (neg_ff[NR-1][l])
               coord_ff[l] <= negv[CoordW-1:0];
            else if (mag > PosLimit)
               coord_ff[l] <= PosLimit[CoordW-1:0];
            else
               coord_ff[l] <= mag[CoordW-1:0];
         end
      end
      assign out_coord[l] = coord_ff[l];
   end

   always_ff @(posedge clock) begin
      if (rdy[NS-1]) sing_ff <= basis.dzero;
   end

   assign in_ready     = rdy[0];
   assign out_valid    = vld_ff[NS-1];
   assign out_singular = sing_ff;

endmodule

### design/affine_coord_3d_cramer_unit.sv
// Affine coordinates of a 3D point by Cramer's rule. Each request beat carries
// one signed Q8.8 point; the unit subtracts the configured origin and returns
// the coordinates along the three configured axes as signed Q16.16, truncated
// toward zero and saturated, or zeros with rsp_singular set when the axes are
// linearly dependent. Throughput is one beat per clock when not stalled; there
// are 4 offset/dot-product stages and 36 divider stages (one quotient bit per
// stage over 33 bits, plus magnitude, seed and clamp stages). Ready runs back
// through the stages combinationally, so bubbles collapse and the unit keeps
// taking beats while a result waits. CSR writes (index 0 origin, 1..3 axes, xyz
// packed in 16-bit lanes) must go in while the unit is empty; the unit does not
// enforce this. Basis cofactors and the determinant are registered after a write.
module affine_coord_3d_cramer_unit (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [15:0]           req_point_x,
   input  logic signed [15:0]           req_point_y,
   input  logic signed [15:0]           req_point_z,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [31:0]           rsp_coord_x,
   output logic signed [31:0]           rsp_coord_y,
   output logic signed [31:0]           rsp_coord_z,
   output logic                         rsp_singular,
   // configuration
   input  logic                         csr_we,
   input  logic [ac3c_pkg::IdxW-1:0]    csr_index,
   input  logic [ac3c_pkg::RegW-1:0]    csr_wdata
);
   import ac3c_pkg::*;

   basis_type           basis;
   numer_type           numer;
   logic                numer_valid, numer_ready;
   logic signed [CoordW-1:0] coord [3];

   // config registers, cofactor vectors, basis determinant
   ac3c_basis u_basis (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .basis     (basis)
   );

   // offset from origin and the three numerator determinants
   ac3c_numer u_numer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_x      (req_point_x),
      .in_y      (req_point_y),
      .in_z      (req_point_z),
      .basis     (basis),
      .out_valid (numer_valid),
      .out_ready (numer_ready),
      .out_numer (numer)
   );

   // three pipelined restoring dividers in lockstep
   ac3c_div u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (numer_valid),
      .in_ready     (numer_ready),
      .in_numer     (numer),
      .basis        (basis),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_coord    (coord),
      .out_singular (rsp_singular)
   );

   assign rsp_coord_x = coord[0];
   assign rsp_coord_y = coord[1];
   assign rsp_coord_z = coord[2];

   // a singular basis never leaks divider garbage
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |->
         rsp_coord_x == '0 && rsp_coord_y == '0 && rsp_coord_z == '0)
      else $error("singular response with nonzero coordinates");

   // a drained output lets backpressure clear all the way to the request side
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response side is ready");

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

### test/ac3c_checker.sv
module ac3c_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic signed [15:0]        req_point_x,
   input  logic signed [15:0]        req_point_y,
   input  logic signed [15:0]        req_point_z,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [31:0]        rsp_coord_x,
   input  logic signed [31:0]        rsp_coord_y,
   input  logic signed [31:0]        rsp_coord_z,
   input  logic                      rsp_singular,
   input  logic                      csr_we,
   input  logic [ac3c_pkg::IdxW-1:0] csr_index,
   input  logic [ac3c_pkg::RegW-1:0] csr_wdata,
   output int                        fail_count,
   output int                        pending
);
   import ac3c_pkg::*;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic               sing;
   } coord_type;

   logic [RegW-1:0] origin_reg, axx_reg, axy_reg, axz_reg;
   coord_type       coord_q[$];

   function automatic longint lane(input logic [RegW-1:0] r, input int k);
      logic signed [15:0] c;
      c = r[16*k +: 16];
      return longint'(c);
   endfunction

   function automatic longint det3(input longint a[3], input longint b[3],
                                   input longint c[3]);
      return a[0]*b[1]*c[2] + b[0]*c[1]*a[2] + c[0]*a[1]*b[2]
           - c[0]*b[1]*a[2] - c[1]*b[2]*a[0] - c[2]*b[0]*a[1];
   endfunction

   // num * 2^16 / den, truncated toward zero, clamped to 32 bits
   function automatic logic [31:0] q16_quot(input longint num, input longint den);
      longint unsigned n, d, qi, r, mag;
      logic neg;
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      neg = (num < 0) != (den < 0);
      qi = n / d;
      r = n % d;
      if (qi > 32768) mag = 64'h1_0000_0000;
      else mag = (qi << 16) + ((r << 16) / d);
      if (neg) begin
         if (mag > 64'h8000_0000) mag = 64'h8000_0000;
         return 32'(-mag);
      end
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return mag[31:0];
   endfunction

   function automatic coord_type solve_coords(input logic signed [15:0] px,
                                              input logic signed [15:0] py,
                                              input logic signed [15:0] pz);
      longint ax[3], ay[3], az[3], v[3], det;
      coord_type c;
      for (int k = 0; k < 3; k++) begin
         ax[k] = lane(axx_reg, k);
         ay[k] = lane(axy_reg, k);
         az[k] = lane(axz_reg, k);
      end
      v[0] = longint'(px) - lane(origin_reg, 0);
      v[1] = longint'(py) - lane(origin_reg, 1);
      v[2] = longint'(pz) - lane(origin_reg, 2);
      det = det3(ax, ay, az);
      if (det == 0) begin
         c = '{cx: 0, cy: 0, cz: 0, sing: 1'b1};
      end else begin
         c.cx = q16_quot(det3(v, ay, az), det);
         c.cy = q16_quot(det3(ax, v, az), det);
         c.cz = q16_quot(det3(ax, ay, v), det);
         c.sing = 1'b0;
      end
      return c;
   endfunction

   assign pending = coord_q.size();

   always @(posedge clock) begin
      coord_type exp_c;
      if (reset) begin
         origin_reg <= OriginRst;
         axx_reg    <= AxisXRst;
         axy_reg    <= AxisYRst;
         axz_reg    <= AxisZRst;
         fail_count <= 0;
         coord_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               RegOrigin: origin_reg <= csr_wdata;
               RegAxisX:  axx_reg    <= csr_wdata;
               RegAxisY:  axy_reg    <= csr_wdata;
               RegAxisZ:  axz_reg    <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            coord_q.push_back(solve_coords(req_point_x, req_point_y, req_point_z));
         if (rsp_valid && rsp_ready) begin
            if (coord_q.size() == 0) begin
               $display("%0t: unexpected beat, actual %h %h %h %b", $time,
                        rsp_coord_x, rsp_coord_y, rsp_coord_z, rsp_singular);
               fail_count <= fail_count + 1;
            end else begin
               exp_c = coord_q.pop_front();
               if (exp_c != {rsp_coord_x, rsp_coord_y, rsp_coord_z, rsp_singular}) begin
                  $display("%0t: mismatch, expected %h %h %h %b, actual %h %h %h %b",
                           $time, exp_c.cx, exp_c.cy, exp_c.cz, exp_c.sing,
                           rsp_coord_x, rsp_coord_y, rsp_coord_z, rsp_singular);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

### test/tb.sv
module tb;
   import ac3c_pkg::*;

   logic               clock, reset;
   logic               req_valid, req_ready;
   logic signed [15:0] req_point_x, req_point_y, req_point_z;
   logic               rsp_valid, rsp_ready;
   logic signed [31:0] rsp_coord_x, rsp_coord_y, rsp_coord_z;
   logic               rsp_singular;
   logic               csr_we;
   logic [IdxW-1:0]    csr_index;
   logic [RegW-1:0]    csr_wdata;
   int                 fail_count, pending;
   int                 idle_cycles;
   bit                 long_hold;   // stimulus asks the receiver for a long stall

   affine_coord_3d_cramer_unit dut (.*);
   ac3c_checker chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // watchdog: cycles with no beat on either side and no csr write
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("tb failed");
         $finish;
      end
   end

   // receiver: random stall per beat, plus one long hold-off on request
   initial begin
      int gap;
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   // one beat on the request side; burst mode skips idling
   task automatic send_point(input logic [15:0] px, input logic [15:0] py,
                             input logic [15:0] pz, input bit burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1;
      req_point_x <= px;
      req_point_y <= py;
      req_point_z <= pz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);   // covers the full pipeline
   endtask

   task automatic write_reg(input logic [IdxW-1:0] idx, input logic [RegW-1:0] val);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 0;
      repeat (8) @(posedge clock);    // let cofactors settle
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'(signed'($urandom_range(0, 1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [RegW-1:0] rand_vec();
      return {rand_comp(), rand_comp(), rand_comp()};
   endfunction

   initial begin
      logic [15:0] edge_vals[5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0100, 16'hFFFF};
      bit burst;
      reset = 1;
      long_hold = 0;
      req_valid = 0;
      req_point_x = 0; req_point_y = 0; req_point_z = 0;
      csr_we = 0; csr_index = 0; csr_wdata = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes under the identity basis after reset
      for (int k = 0; k < 5; k++)
         send_point(edge_vals[k], edge_vals[4-k], edge_vals[(k+2)%5], 0);
      send_point(16'h0180, 16'hFE80, 16'h0040, 0);
      drain();

      // tiny axes push quotients into saturation, both signs
      write_reg(RegAxisX, 48'h0000_0000_0001);
      write_reg(RegAxisY, 48'h0000_0001_0000);
      write_reg(RegAxisZ, 48'h0001_0000_0000);
      write_reg(RegOrigin, {16'h8000, 16'h7FFF, 16'h8000});
      for (int k = 0; k < 5; k++)
         send_point(edge_vals[k], edge_vals[(k+1)%5], edge_vals[(k+3)%5], 0);
      drain();

      // singular basis (two equal axes); also unused indices and high-bit garbage
      write_reg(RegAxisY, 48'h0000_0000_0001);
      write_reg(3'd5, 48'hFFFF_FFFF_FFFF);
      write_reg(3'd7, 48'h1234_5678_9ABC);
      for (int k = 0; k < 4; k++)
         send_point(edge_vals[k], edge_vals[k+1], edge_vals[k], 0);
      drain();

      // extreme-magnitude basis
      write_reg(RegAxisX, {16'h8000, 16'h7FFF, 16'h8000});
      write_reg(RegAxisY, {16'h7FFF, 16'h8000, 16'h8000});
      write_reg(RegAxisZ, {16'h8000, 16'h8000, 16'h7FFF});
      write_reg(RegOrigin, {16'h7FFF, 16'h8000, 16'h7FFF});
      for (int k = 0; k < 5; k++)
         send_point(edge_vals[k], edge_vals[k], edge_vals[4-k], 0);
      drain();

      // random phases with fresh bases; one phase stalls the receiver long
      for (int phase = 0; phase < 11; phase++) begin
         if ($urandom_range(0, 4) == 0) begin
            write_reg(RegAxisX, rand_vec());
            write_reg(RegAxisY, $urandom_range(0, 1) ? rand_vec() : chk.axx_reg);
         end else begin
            write_reg(RegAxisX, rand_vec());
            write_reg(RegAxisY, rand_vec());
         end
         write_reg(RegAxisZ, rand_vec());
         write_reg(RegOrigin, rand_vec());
         if (phase == 3) long_hold = 1;
         for (int n = 0; n < 100; n++) begin
            burst = (phase == 3) || ($urandom_range(0, 3) == 0);
            send_point(rand_comp(), rand_comp(), rand_comp(), burst);
         end
         drain();
      end

      if (fail_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end
endmodule
